// File: rtl/pfe_pkg.sv
// Shared types, constants and symbol decoding for the postfix stack evaluator.
`default_nettype none

package pfe_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int DATA_W          = 32;
   localparam int SYM_W           = 8;
   localparam int STATUS_W        = 3;

   localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_STAR    = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_SLASH   = 8'h2F;
   localparam logic [SYM_W-1:0] SYM_PERCENT = 8'h25;
   localparam logic [SYM_W-1:0] SYM_CARET   = 8'h5E;
   localparam logic [SYM_W-1:0] SYM_ZERO    = 8'h30;

   localparam logic [STATUS_W-1:0] FLAG_NONE  = 3'b000;
   localparam logic [STATUS_W-1:0] FLAG_UNDER = 3'b001;
   localparam logic [STATUS_W-1:0] FLAG_OVER  = 3'b010;
   localparam logic [STATUS_W-1:0] FLAG_DIVZ  = 3'b100;

   localparam logic [DATA_W-1:0] POP_EMPTY = {DATA_W{1'b1}};

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_MOD,
      OP_POW
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_FINAL
   } state_type;

   typedef enum logic [2:0] {
      AL_IDLE,
      AL_ARITH,
      AL_DIV,
      AL_SIGN,
      AL_POW
   } alu_state_type;

   typedef struct packed {
      logic              start;
      op_type            op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic              divz;
      logic [DATA_W-1:0] value;
   } alu_rsp_type;

   function automatic logic is_operator(input logic [SYM_W-1:0] sym);
      return (sym == SYM_PLUS) || (sym == SYM_MINUS) || (sym == SYM_STAR) ||
             (sym == SYM_SLASH) || (sym == SYM_PERCENT) || (sym == SYM_CARET);
   endfunction

   function automatic op_type decode_op(input logic [SYM_W-1:0] sym);
      op_type op;
      unique case (sym)
         SYM_PLUS:    op = OP_ADD;
         SYM_MINUS:   op = OP_SUB;
         SYM_STAR:    op = OP_MUL;
         SYM_SLASH:   op = OP_DIV;
         SYM_PERCENT: op = OP_MOD;
         SYM_CARET:   op = OP_POW;
         default:     op = OP_ADD;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pfe_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/pfe_alu.sv
// Multicycle arithmetic unit: add, subtract, multiply, radix-2 divide and modulo, power.
`default_nettype none

module pfe_alu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pfe_pkg::alu_req_type req,
   output pfe_pkg::alu_rsp_type      rsp
);

   localparam int W     = pfe_pkg::DATA_W;
   localparam int CNT_W = $clog2(W);

   pfe_pkg::alu_state_type state_ff, state_in;
   pfe_pkg::op_type        op_ff, op_in;
   logic [W-1:0]           a_ff, a_in;
   logic [W-1:0]           b_ff, b_in;
   logic [W-1:0]           e_ff, e_in;
   logic [W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_a_ff, neg_a_in;
   logic                   neg_b_ff, neg_b_in;
   logic                   done_ff, done_in;
   logic                   divz_ff, divz_in;
   logic [W-1:0]           res_ff, res_in;
   logic [W:0]             rem_shift;
   logic [W:0]             rem_diff;

   assign rem_shift = {rem_ff, a_ff[W-1]};
   assign rem_diff  = rem_shift - {1'b0, b_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfe_pkg::AL_IDLE: begin
            if (req.start) begin
               case (req.op) inside
                  pfe_pkg::OP_DIV, pfe_pkg::OP_MOD:
                     state_in = (req.b == '0) ? pfe_pkg::AL_IDLE : pfe_pkg::AL_DIV;
                  pfe_pkg::OP_POW:
                     state_in = req.b[W-1] ? pfe_pkg::AL_IDLE : pfe_pkg::AL_POW;
                  default:
                     state_in = pfe_pkg::AL_ARITH;
               endcase
            end
         end
         pfe_pkg::AL_ARITH: state_in = pfe_pkg::AL_IDLE;
         pfe_pkg::AL_DIV: begin
            if (cnt_ff == CNT_W'(W - 1)) begin
               state_in = pfe_pkg::AL_SIGN;
            end
         end
         pfe_pkg::AL_SIGN: state_in = pfe_pkg::AL_IDLE;
         pfe_pkg::AL_POW: begin
            if (e_ff == '0) begin
               state_in = pfe_pkg::AL_IDLE;
            end
         end
         default: state_in = pfe_pkg::AL_IDLE;
      endcase
   end

   always_comb begin
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      e_in     = e_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      divz_in  = 1'b0;
      unique case (state_ff)
         pfe_pkg::AL_IDLE: begin
            if (req.start) begin
               op_in = req.op;
               case (req.op) inside
                  pfe_pkg::OP_DIV, pfe_pkg::OP_MOD: begin
                     if (req.b == '0) begin
                        res_in  = '0;
                        divz_in = 1'b1;
                        done_in = 1'b1;
                     end else begin
                        a_in     = req.a[W-1] ? (W'(0) - req.a) : req.a;
                        b_in     = req.b[W-1] ? (W'(0) - req.b) : req.b;
                        rem_in   = '0;
                        cnt_in   = '0;
                        neg_a_in = req.a[W-1];
                        neg_b_in = req.b[W-1];
                     end
                  end
                  pfe_pkg::OP_POW: begin
                     if (req.b[W-1]) begin
                        done_in = 1'b1;
                        if (req.a == W'(1)) begin
                           res_in = W'(1);
                        end else if (req.a == pfe_pkg::POP_EMPTY) begin
                           res_in = req.b[0] ? pfe_pkg::POP_EMPTY : W'(1);
                        end else begin
                           res_in = '0;
                        end
                     end else begin
                        a_in = W'(1);
                        b_in = req.a;
                        e_in = req.b;
                     end
                  end
                  default: begin
                     a_in = req.a;
                     b_in = req.b;
                  end
               endcase
            end
         end
         pfe_pkg::AL_ARITH: begin
            done_in = 1'b1;
            case (op_ff)
               pfe_pkg::OP_SUB: res_in = a_ff - b_ff;
               pfe_pkg::OP_MUL: res_in = a_ff * b_ff;
               default:         res_in = a_ff + b_ff;
            endcase
         end
         pfe_pkg::AL_DIV: begin
            if (!rem_diff[W]) begin
               rem_in = rem_diff[W-1:0];
            end else begin
               rem_in = rem_shift[W-1:0];
            end
            a_in   = {a_ff[W-2:0], ~rem_diff[W]};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         pfe_pkg::AL_SIGN: begin
            done_in = 1'b1;
            if (op_ff == pfe_pkg::OP_MOD) begin
               res_in = neg_a_ff ? (W'(0) - rem_ff) : rem_ff;
            end else begin
               res_in = (neg_a_ff ^ neg_b_ff) ? (W'(0) - a_ff) : a_ff;
            end
         end
         pfe_pkg::AL_POW: begin
            if (e_ff != '0) begin
               if (e_ff[0]) begin
                  a_in = a_ff * b_ff;
               end
               b_in = b_ff * b_ff;
               e_in = e_ff >> 1;
            end else begin
               res_in  = a_ff;
               done_in = 1'b1;
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfe_pkg::AL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      e_ff     <= e_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      divz_ff  <= divz_in;
      res_ff   <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.divz  = divz_ff;
   assign rsp.value = res_ff;

endmodule

`default_nettype wire

// File: rtl/postfix_stack_evaluator_core.sv
// Top level of the postfix stack evaluator: stack control, stack memory and result register.
`default_nettype none

// The block takes one symbol byte per beat and keeps the operand stack in a
// synchronous RAM, with the top value mirrored in a register. An operand beat
// is pushed into the RAM; when it carries the last mark, the block goes on to
// present the result from its final state. An operator beat reads the second
// operand from the RAM and runs the arithmetic unit for add, subtract and
// multiply, divide and modulo (one quotient bit per cycle), and power
// (one exponent bit per squaring step). The result is held
// in an output register, so the next expression may start while it waits to
// be taken. No clearing pass follows reset; only stacked entries are read.
module postfix_stack_evaluator_core #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [pfe_pkg::SYM_W-1:0]    req_symbol,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [pfe_pkg::DATA_W-1:0]   rsp_value,
   output logic             [pfe_pkg::STATUS_W-1:0] rsp_status
);

   localparam int W      = pfe_pkg::DATA_W;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   pfe_pkg::state_type             state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [W-1:0]                   top_ff, top_in;
   logic [pfe_pkg::STATUS_W-1:0]   flags_ff, flags_in;
   logic                           last_ff, last_in;
   pfe_pkg::op_type                op_ff, op_in;
   logic [W-1:0]                   b_ff, b_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                   rsp_value_ff, rsp_value_in;
   logic [pfe_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                           req_accept;
   logic                           out_free;
   logic                           sym_is_op;
   logic [W-1:0]                   operand;
   logic                           count_nz;
   logic                           stack_full;
   logic [CNT_W-1:0]               count_dec;
   logic [CNT_W-1:0]               count_dec2;

   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic [W-1:0]                   wr_data;
   logic                           rd_en;
   logic [ADDR_W-1:0]              rd_addr;
   logic [W-1:0]                   rd_data;

   pfe_pkg::alu_req_type           alu_req;
   pfe_pkg::alu_rsp_type           alu_rsp;

   pfe_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfe_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign req_stall  = (state_ff != pfe_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sym_is_op  = pfe_pkg::is_operator(req_symbol);
   assign operand    = {{(W - pfe_pkg::SYM_W){1'b0}}, req_symbol} -
                       {{(W - pfe_pkg::SYM_W){1'b0}}, pfe_pkg::SYM_ZERO};
   assign count_nz   = (count_ff != '0);
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign count_dec  = count_ff - CNT_W'(1);
   assign count_dec2 = count_ff - CNT_W'(2);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (sym_is_op) begin
                  state_in = pfe_pkg::ST_READ;
               end else if (req_last) begin
                  state_in = pfe_pkg::ST_FINAL;
               end
            end
         end
         pfe_pkg::ST_READ: state_in = pfe_pkg::ST_EXEC;
         pfe_pkg::ST_EXEC: begin
            if (alu_rsp.done) begin
               state_in = last_ff ? pfe_pkg::ST_FINAL : pfe_pkg::ST_IDLE;
            end
         end
         pfe_pkg::ST_FINAL: begin
            if (out_free) begin
               state_in = pfe_pkg::ST_IDLE;
            end
         end
         default: state_in = pfe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      top_in        = top_ff;
      flags_in      = flags_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      b_in          = b_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_data       = operand;
      rd_en         = 1'b0;
      rd_addr       = count_dec2[ADDR_W-1:0];
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;
      alu_req.a     = rd_data;
      alu_req.b     = b_ff;
      unique case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (req_accept) begin
               last_in = req_last;
               if (sym_is_op) begin
                  op_in = pfe_pkg::decode_op(req_symbol);
                  rd_en = 1'b1;
                  if (count_nz) begin
                     b_in     = top_ff;
                     count_in = count_dec;
                  end else begin
                     b_in     = pfe_pkg::POP_EMPTY;
                     flags_in = flags_ff | pfe_pkg::FLAG_UNDER;
                  end
               end else if (!stack_full) begin
                  wr_en    = 1'b1;
                  top_in   = operand;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  flags_in = flags_ff | pfe_pkg::FLAG_OVER;
               end
            end
         end
         pfe_pkg::ST_READ: begin
            alu_req.start = 1'b1;
            if (count_nz) begin
               count_in = count_dec;
            end else begin
               alu_req.a = pfe_pkg::POP_EMPTY;
               flags_in  = flags_ff | pfe_pkg::FLAG_UNDER;
            end
         end
         pfe_pkg::ST_EXEC: begin
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               wr_data  = alu_rsp.value;
               top_in   = alu_rsp.value;
               count_in = count_ff + CNT_W'(1);
               if (alu_rsp.divz) begin
                  flags_in = flags_ff | pfe_pkg::FLAG_DIVZ;
               end
            end
         end
         pfe_pkg::ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = count_nz ? top_ff : pfe_pkg::POP_EMPTY;
               rsp_status_in = flags_ff |
                               (count_nz ? pfe_pkg::FLAG_NONE : pfe_pkg::FLAG_UNDER);
               count_in      = '0;
               flags_in      = pfe_pkg::FLAG_NONE;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfe_pkg::ST_IDLE;
         count_ff     <= '0;
         flags_ff     <= pfe_pkg::FLAG_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      last_ff       <= last_in;
      op_ff         <= op_in;
      b_ff          <= b_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire
